/* hw/rtl/pgpsig_pkg.sv */
// ----------------------------------------------------------------------------
// pgpsig_pkg: shared types and constants of the signature packet parser
// byte transaction, result transaction, queue entry, parser phases and codes
// ----------------------------------------------------------------------------
package pgpsig_pkg;

	// queue between the front and the back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// result kinds
	localparam logic [1:0] KIND_HASHED = 2'd0;
	localparam logic [1:0] KIND_SIG    = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;
	localparam logic [1:0] KIND_END    = 2'd3;

	// error codes
	localparam logic [2:0] ERR_SHORT     = 3'd0;
	localparam logic [2:0] ERR_OLD_FMT   = 3'd1;
	localparam logic [2:0] ERR_NOT_SIG   = 3'd2;
	localparam logic [2:0] ERR_BAD_LEN   = 3'd3;
	localparam logic [2:0] ERR_BODY      = 3'd4;
	localparam logic [2:0] ERR_VERSION   = 3'd5;
	localparam logic [2:0] ERR_TYPE      = 3'd6;
	localparam logic [2:0] ERR_TRUNCATED = 3'd7;

	// header bytes and body values
	localparam logic [4:0] TAG_SIGNATURE = 5'd2;
	localparam logic [7:0] SIG_VERSION   = 8'd4;
	localparam logic [7:0] SIG_TYPE      = 8'd0;
	localparam logic [7:0] LEN_TWO_BASE  = 8'd192;
	localparam logic [7:0] LEN_BAD_BASE  = 8'd224;
	localparam logic [7:0] LEN_FIVE_MARK = 8'd255;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_HEAD,
		PH_LEN5,
		PH_VT,
		PH_HSIZE,
		PH_HASHED,
		PH_USIZE,
		PH_UNHASHED,
		PH_PREFIX,
		PH_SIGBITS,
		PH_SIGDATA
	} phase_t;

	// class of a byte taken as the first length octet
	typedef enum logic [1:0] {
		LEN_ONE,
		LEN_TWO,
		LEN_BAD,
		LEN_FIVE
	} len_cls_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
		logic       last;
	} pkt_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  out_byte;
		logic [2:0]  error_code;
		logic [31:0] packet_length;
		logic [7:0]  pubkey_algo;
		logic [7:0]  hash_algo;
		logic [15:0] hashed_area_size;
		logic [15:0] unhashed_area_size;
		logic [15:0] sig_number_bits;
		logic        end_mark;
	} pkt_out_t;

	// queued transaction with its byte classification
	typedef struct packed {
		pkt_in_t  item;
		len_cls_t len_cls;
		logic     new_fmt;
		logic     sig_tag;
	} queue_entry_t;

	function automatic len_cls_t classify_len(input logic [7:0] b);
		len_cls_t c;
		if (b < LEN_TWO_BASE) begin
			c = LEN_ONE;
		end else if (b < LEN_BAD_BASE) begin
			c = LEN_TWO;
		end else if (b == LEN_FIVE_MARK) begin
			c = LEN_FIVE;
		end else begin
			c = LEN_BAD;
		end
		return c;
	endfunction

endpackage

/* hw/rtl/pgpsig_front.sv */
// ----------------------------------------------------------------------------
// pgpsig_front: byte intake and classification
// accepts byte transactions, tags each with header flags, and queues them
// ----------------------------------------------------------------------------
module pgpsig_front import pgpsig_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         byte_valid,
	output logic         byte_ready,
	input  pkt_in_t      byte_item,
	output logic         q_valid,
	input  logic         q_pop,
	output queue_entry_t q_entry
);

	localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

	queue_entry_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]       wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]       rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]       count_q;
	queue_entry_t                 new_entry;
	logic                         push;
	logic                         pop;

	assign byte_ready = (count_q != CNT_FULL);
	assign push       = byte_valid && byte_ready;
	assign q_valid    = (count_q != '0);
	assign pop        = q_pop && q_valid;
	assign q_entry    = mem_q[rd_ptr_q];

	// header flags, meaningful only where the parser looks at them
	always_comb begin
		new_entry.item    = byte_item;
		new_entry.len_cls = classify_len(byte_item.data_byte);
		new_entry.new_fmt = byte_item.data_byte[7];
		new_entry.sig_tag = (byte_item.data_byte[4:0] == TAG_SIGNATURE);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count beyond depth");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CNT_FULL) && !pop |=> (count_q == CNT_FULL))
		else $error("full queue lost an entry without a pop");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) && byte_valid |=> (count_q != '0))
		else $error("empty queue refused a transaction");

endmodule

/* hw/rtl/pgpsig_back.sv */
// ----------------------------------------------------------------------------
// pgpsig_back: packet parser and result register
// runs the header and body state machine on queued bytes; unless a held result stalls it, one per cycle
// ----------------------------------------------------------------------------
module pgpsig_back import pgpsig_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	output logic         q_pop,
	input  queue_entry_t q_entry,
	output logic         res_valid,
	input  logic         res_ready,
	output pkt_out_t     res_item
);

	phase_t      phase_q, phase_d;
	logic [2:0]  hc_q, hc_d;
	logic        newf_q, newf_d;
	logic        sigt_q, sigt_d;
	len_cls_t    lcls_q, lcls_d;
	logic [4:0]  lfh_q, lfh_d;
	logic [31:0] len_q, len_d;
	logic [15:0] fc_q, fc_d;
	logic [7:0]  ver_q, ver_d;
	logic [7:0]  typ_q, typ_d;
	logic [7:0]  pk_q, pk_d;
	logic [7:0]  ha_q, ha_d;
	logic [15:0] hs_q, hs_d;
	logic [15:0] us_q, us_d;
	logic [15:0] sb_q, sb_d;

	logic        out_valid_q;
	pkt_out_t    out_q;

	logic        has_res;
	logic        fail;
	logic [2:0]  fail_code;
	logic [1:0]  res_kind;
	logic [7:0]  res_byte;
	logic [2:0]  ofs;
	logic [2:0]  k;
	logic [7:0]  b;
	logic        l;
	pkt_out_t    res_d;

	assign q_pop     = q_valid && (!out_valid_q || res_ready);
	assign res_valid = out_valid_q;
	assign res_item  = out_q;
	assign b         = q_entry.item.data_byte;
	assign l         = q_entry.item.last;

	always_comb begin
		phase_d   = phase_q;
		hc_d      = hc_q;
		newf_d    = newf_q;
		sigt_d    = sigt_q;
		lcls_d    = lcls_q;
		lfh_d     = lfh_q;
		len_d     = len_q;
		fc_d      = fc_q;
		ver_d     = ver_q;
		typ_d     = typ_q;
		pk_d      = pk_q;
		ha_d      = ha_q;
		hs_d      = hs_q;
		us_d      = us_q;
		sb_d      = sb_q;
		has_res   = 1'b0;
		fail      = 1'b0;
		fail_code = ERR_SHORT;
		res_kind  = KIND_HASHED;
		res_byte  = '0;
		ofs       = 3'd6;
		k         = '0;

		if (q_pop && q_entry.item.first) begin
			phase_d = PH_HEAD;
			hc_d    = '0;
			newf_d  = 1'b0;
			sigt_d  = 1'b0;
			lcls_d  = LEN_ONE;
			lfh_d   = '0;
			len_d   = '0;
			fc_d    = '0;
			ver_d   = '0;
			typ_d   = '0;
			pk_d    = '0;
			ha_d    = '0;
			hs_d    = '0;
			us_d    = '0;
			sb_d    = '0;
		end

		if (q_pop) begin
			case (phase_d)
				PH_HEAD: begin
					if (hc_d == 3'd0) begin
						newf_d = q_entry.new_fmt;
						sigt_d = q_entry.sig_tag;
					end else if (hc_d == 3'd1) begin
						lcls_d = q_entry.len_cls;
						lfh_d  = b[4:0];
						len_d  = (q_entry.len_cls == LEN_ONE) ? {24'd0, b} : '0;
					end
					case (lcls_d)
						LEN_ONE: ofs = 3'd2;
						LEN_TWO: ofs = 3'd3;
						default: ofs = 3'd6;
					endcase
					if (hc_d >= 3'd2) begin
						if (hc_d < ofs) begin
							if (lcls_d == LEN_TWO) begin
								if (hc_d == 3'd2) begin
									len_d = {19'd0, lfh_d, 8'd0} + {24'd0, b}
										+ {24'd0, LEN_TWO_BASE};
								end
							end else if (lcls_d == LEN_FIVE) begin
								len_d = {len_d[23:0], b};
							end
						end else begin
							k = hc_d - ofs;
							case (k)
								3'd0: ver_d = b;
								3'd1: typ_d = b;
								3'd2: pk_d  = b;
								3'd3: ha_d  = b;
								default: ;
							endcase
						end
					end
					if (hc_d < 3'd4) begin
						if (l) begin
							fail = 1'b1; fail_code = ERR_SHORT;
						end
					end else if (!newf_d) begin
						fail = 1'b1; fail_code = ERR_OLD_FMT;
					end else if (!sigt_d) begin
						fail = 1'b1; fail_code = ERR_NOT_SIG;
					end else if (lcls_d == LEN_BAD) begin
						fail = 1'b1; fail_code = ERR_BAD_LEN;
					end else if (lcls_d == LEN_FIVE) begin
						if (l) begin
							fail = 1'b1; fail_code = ERR_TRUNCATED;
						end else begin
							phase_d = PH_LEN5;
						end
					end else if (l) begin
						fail = 1'b1; fail_code = ERR_BODY;
					end else begin
						fc_d    = {13'd0, 3'd5 - ofs};
						phase_d = PH_VT;
					end
					hc_d = hc_d + 3'd1;
				end
				PH_LEN5: begin
					len_d = {len_d[23:0], b};
					if (l) begin
						fail = 1'b1; fail_code = ERR_BODY;
					end else begin
						fc_d    = '0;
						phase_d = PH_VT;
					end
				end
				PH_VT: begin
					case (fc_d[1:0])
						2'd0: ver_d = b;
						2'd1: typ_d = b;
						2'd2: pk_d  = b;
						2'd3: ha_d  = b;
						default: ;
					endcase
					if (fc_d[1:0] != 2'd3) begin
						fc_d = {14'd0, fc_d[1:0] + 2'd1};
						if (l) begin
							fail = 1'b1; fail_code = ERR_BODY;
						end
					end else if (ver_d != SIG_VERSION) begin
						fail = 1'b1; fail_code = ERR_VERSION;
					end else if (typ_d != SIG_TYPE) begin
						fail = 1'b1; fail_code = ERR_TYPE;
					end else if (l) begin
						fail = 1'b1; fail_code = ERR_TRUNCATED;
					end else begin
						hc_d    = '0;
						phase_d = PH_HSIZE;
					end
				end
				PH_HSIZE, PH_USIZE, PH_SIGBITS: begin
					if (hc_d == 3'd0) begin
						case (phase_d)
							PH_HSIZE: hs_d[15:8] = b;
							PH_USIZE: us_d[15:8] = b;
							default:  sb_d[15:8] = b;
						endcase
						hc_d = 3'd1;
						if (l) begin
							fail = 1'b1; fail_code = ERR_TRUNCATED;
						end
					end else begin
						hc_d = '0;
						case (phase_d)
							PH_HSIZE: begin
								hs_d[7:0] = b;
								if (l) begin
									fail = 1'b1; fail_code = ERR_TRUNCATED;
								end else if (hs_d != '0) begin
									fc_d    = hs_d;
									phase_d = PH_HASHED;
								end else begin
									phase_d = PH_USIZE;
								end
							end
							PH_USIZE: begin
								us_d[7:0] = b;
								if (l) begin
									fail = 1'b1; fail_code = ERR_TRUNCATED;
								end else if (us_d != '0) begin
									fc_d    = us_d;
									phase_d = PH_UNHASHED;
								end else begin
									fc_d    = 16'd2;
									phase_d = PH_PREFIX;
								end
							end
							default: begin
								sb_d[7:0] = b;
								if (l) begin
									// signature with no data bytes
									has_res  = 1'b1;
									res_kind = KIND_END;
									phase_d  = PH_IDLE;
								end else begin
									phase_d = PH_SIGDATA;
								end
							end
						endcase
					end
				end
				PH_HASHED: begin
					if (l) begin
						fail = 1'b1; fail_code = ERR_TRUNCATED;
					end else begin
						fc_d = fc_d - 16'd1;
						if (fc_d == '0) begin
							phase_d = PH_USIZE;
						end
						has_res  = 1'b1;
						res_kind = KIND_HASHED;
						res_byte = b;
					end
				end
				PH_UNHASHED: begin
					if (l) begin
						fail = 1'b1; fail_code = ERR_TRUNCATED;
					end else begin
						fc_d = fc_d - 16'd1;
						if (fc_d == '0) begin
							fc_d    = 16'd2;
							phase_d = PH_PREFIX;
						end
					end
				end
				PH_PREFIX: begin
					if (l) begin
						fail = 1'b1; fail_code = ERR_TRUNCATED;
					end else begin
						fc_d = fc_d - 16'd1;
						if (fc_d == '0) begin
							hc_d    = '0;
							phase_d = PH_SIGBITS;
						end
					end
				end
				PH_SIGDATA: begin
					if (l) begin
						phase_d = PH_IDLE;
					end
					has_res  = 1'b1;
					res_kind = KIND_SIG;
					res_byte = b;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		if (fail) begin
			phase_d  = PH_IDLE;
			has_res  = 1'b1;
			res_kind = KIND_ERROR;
			res_byte = '0;
		end

		res_d.kind               = res_kind;
		res_d.out_byte           = res_byte;
		res_d.error_code         = fail ? fail_code : ERR_SHORT;
		res_d.packet_length      = len_d;
		res_d.pubkey_algo        = pk_d;
		res_d.hash_algo          = ha_d;
		res_d.hashed_area_size   = hs_d;
		res_d.unhashed_area_size = us_d;
		res_d.sig_number_bits    = sb_d;
		res_d.end_mark           = l;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			hc_q        <= '0;
			newf_q      <= 1'b0;
			sigt_q      <= 1'b0;
			lcls_q      <= LEN_ONE;
			lfh_q       <= '0;
			len_q       <= '0;
			fc_q        <= '0;
			ver_q       <= '0;
			typ_q       <= '0;
			pk_q        <= '0;
			ha_q        <= '0;
			hs_q        <= '0;
			us_q        <= '0;
			sb_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			hc_q    <= hc_d;
			newf_q  <= newf_d;
			sigt_q  <= sigt_d;
			lcls_q  <= lcls_d;
			lfh_q   <= lfh_d;
			len_q   <= len_d;
			fc_q    <= fc_d;
			ver_q   <= ver_d;
			typ_q   <= typ_d;
			pk_q    <= pk_d;
			ha_q    <= ha_d;
			hs_q    <= hs_d;
			us_q    <= us_d;
			sb_q    <= sb_d;
			if (q_pop && has_res) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && has_res) begin
			out_q <= res_d;
		end
	end

	a_countdown_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HASHED) || (phase_q == PH_UNHASHED) || (phase_q == PH_PREFIX)
		|-> (fc_q != '0))
		else $error("byte countdown reached zero inside an area");

	a_err_code_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.kind != KIND_ERROR) |-> (out_q.error_code == ERR_SHORT))
		else $error("error code set on a non-error result");

	a_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ((out_q.kind == KIND_ERROR) || (out_q.kind == KIND_END))
		|-> (out_q.out_byte == '0))
		else $error("byte carried on an error or end result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_ready |-> !q_pop)
		else $error("parser advanced while result register was held");

endmodule

/* hw/rtl/openpgp_signature_packet_parser.sv */
// ----------------------------------------------------------------------------
// openpgp_signature_packet_parser: v4 signature packet parser
// new-format header and length decode, version and type checks, hashed
// subpacket bytes and signature data out; unless a held result stalls it, one byte transaction per cycle
// ----------------------------------------------------------------------------
// path: a byte transaction passes through the intake queue, then the result
//   register, before any result that it yields is presented
// throughput: one byte per cycle while no held result stalls the parser
// the two-entry intake queue absorbs up to two bytes while a result waits
// reset: arst_n clears the queue, the result valid and all parser state,
//   leaving the parser idle until a byte marked first arrives
module openpgp_signature_packet_parser import pgpsig_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	// byte transactions in
	input  logic     byte_valid,
	output logic     byte_ready,
	input  pkt_in_t  byte_item,
	// result transactions out
	output logic     res_valid,
	input  logic     res_ready,
	output pkt_out_t res_item
);

	// queue handshake between intake and parser
	logic         q_valid;
	logic         q_pop;
	queue_entry_t q_entry;

	// intake: classifies tag and length octets and buffers transactions
	pgpsig_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_entry    (q_entry)
	);

	// parser: pops one entry whenever the result register is empty or being
	// drained, so it holds, whatever the byte, while a result waits downstream
	pgpsig_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_entry   (q_entry),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule
